// ----- rtl/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU write-back cache tags.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

  localparam int unsigned ADDRESS_W = 48;
  localparam int unsigned MODE_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // Flags of one result transaction
  typedef struct packed {
    logic hit;
    logic forward_read;
    logic writeback_valid;
    logic fault;
  } flags_t;

endpackage

`default_nettype wire

// ----- rtl/set_assoc_lru_writeback_cache_tags.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_tags
// Tag and true-LRU policy engine of a set-associative, write-back,
// write-allocate cache. One result transaction per access transaction.
// ----------------------------------------------------------------------------
// Channel | Handshake             | Payload
// --------+-----------------------+--------------------------------------------
// in      | in_valid / in_ready   | mode, address
// out     | out_valid / out_ready | hit, forward_read, writeback_valid,
//         |                       | writeback_address, fault
//
// An access is read from the set memory at acceptance, resolved in the next
// cycle and written back as the result register loads, one access per cycle
// sustained while the result channel does not stall, with the row written by
// the access ahead forwarded into a same-set read. After reset a clearing
// pass walks the set memory one row a cycle over every set, in_ready low. A
// stalled result holds the resolve stage; in_ready drops only when both are
// full or while clearing. LINE_BYTES, SETS must be powers of two (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_writeback_cache_tags #(
  parameter int unsigned SETS       = 1024,
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [salc_pkg::MODE_W-1:0]      mode,
  input  wire logic [salc_pkg::ADDRESS_W-1:0]   address,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  hit,
  output logic                                  forward_read,
  output logic                                  writeback_valid,
  output logic [salc_pkg::ADDRESS_W-1:0]        writeback_address,
  output logic                                  fault
);

  localparam int unsigned OFF_W     = $clog2(LINE_BYTES);
  localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned TAG_SHIFT = OFF_W + ((SETS > 1) ? $clog2(SETS) : 0);
  localparam int unsigned RANK_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Set memory, one row per set
  logic [WAYS-1:0]                 mem_valid [SETS];
  logic [WAYS-1:0]                 mem_dirty [SETS];
  logic [WAYS-1:0][RANK_W-1:0]     mem_rank  [SETS];
  logic [WAYS-1:0][ADDR_BITS-1:0]  mem_addr  [SETS];

  logic                            clearing;
  logic [SET_W-1:0]                clr_idx;

  logic [salc_pkg::ADDRESS_W-1:0]  addr_ext;
  logic [SET_W-1:0]                in_set;
  logic                            in_accept;

  logic                            s1_valid;
  salc_pkg::mode_t                 s1_mode;
  logic [ADDR_BITS-1:0]            s1_addr;
  logic [SET_W-1:0]                s1_set;
  logic [WAYS-1:0]                 rd_valid;
  logic [WAYS-1:0]                 rd_dirty;
  logic [WAYS-1:0][RANK_W-1:0]     rd_rank;
  logic [WAYS-1:0][ADDR_BITS-1:0]  rd_addr;
  logic                            s1_adv;

  salc_pkg::flags_t                flags;
  logic [ADDR_BITS-1:0]            wb_addr;
  logic                            update;
  logic                            wr_en;
  logic [WAYS-1:0]                 new_valid;
  logic [WAYS-1:0]                 new_dirty;
  logic [WAYS-1:0][RANK_W-1:0]     new_rank;
  logic [WAYS-1:0][ADDR_BITS-1:0]  new_addr;

  assign addr_ext  = salc_pkg::ADDRESS_W'(address[ADDR_BITS-1:0]);
  assign in_set    = (SETS > 1) ? addr_ext[OFF_W +: SET_W] : '0;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !clearing && (!s1_valid || s1_adv);
  assign in_accept = in_valid && in_ready;
  assign wr_en     = s1_adv && update;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + SET_W'(1);
      if (clr_idx == SET_W'(SETS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem_valid[clr_idx] <= '0;
      mem_dirty[clr_idx] <= '0;
      mem_rank[clr_idx]  <= '0;
      mem_addr[clr_idx]  <= '0;
    end else if (wr_en) begin
      mem_valid[s1_set] <= new_valid;
      mem_dirty[s1_set] <= new_dirty;
      mem_rank[s1_set]  <= new_rank;
      mem_addr[s1_set]  <= new_addr;
    end
  end

  // Read at acceptance; take the row being written when the set matches
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (wr_en && (s1_set == in_set)) begin
        rd_valid <= new_valid;
        rd_dirty <= new_dirty;
        rd_rank  <= new_rank;
        rd_addr  <= new_addr;
      end else begin
        rd_valid <= mem_valid[in_set];
        rd_dirty <= mem_dirty[in_set];
        rd_rank  <= mem_rank[in_set];
        rd_addr  <= mem_addr[in_set];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode <= salc_pkg::mode_t'(mode);
      s1_addr <= address[ADDR_BITS-1:0];
      s1_set  <= in_set;
    end
  end

  salc_policy #(
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS),
    .TAG_SHIFT (TAG_SHIFT),
    .RANK_W    (RANK_W)
  ) u_policy (
    .mode      (s1_mode),
    .addr      (s1_addr),
    .way_valid (rd_valid),
    .way_dirty (rd_dirty),
    .way_rank  (rd_rank),
    .way_addr  (rd_addr),
    .flags     (flags),
    .wb_addr   (wb_addr),
    .update    (update),
    .new_valid (new_valid),
    .new_dirty (new_dirty),
    .new_rank  (new_rank),
    .new_addr  (new_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hit               <= flags.hit;
      forward_read      <= flags.forward_read;
      writeback_valid   <= flags.writeback_valid;
      writeback_address <= salc_pkg::ADDRESS_W'(wb_addr);
      fault             <= flags.fault;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/salc_policy.sv -----
// ----------------------------------------------------------------------------
// salc_policy
// Tag compare, hit/allocate decision, true-LRU rank update and victim
// selection for one set row.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_policy #(
  parameter int unsigned WAYS      = 8,
  parameter int unsigned ADDR_BITS = 48,
  parameter int unsigned TAG_SHIFT = 16,
  parameter int unsigned RANK_W    = 3
) (
  input  var salc_pkg::mode_t                   mode,
  input  wire logic [ADDR_BITS-1:0]             addr,
  input  wire logic [WAYS-1:0]                  way_valid,
  input  wire logic [WAYS-1:0]                  way_dirty,
  input  wire logic [WAYS-1:0][RANK_W-1:0]      way_rank,
  input  wire logic [WAYS-1:0][ADDR_BITS-1:0]   way_addr,
  output salc_pkg::flags_t                      flags,
  output logic [ADDR_BITS-1:0]                  wb_addr,
  output logic                                  update,
  output logic [WAYS-1:0]                       new_valid,
  output logic [WAYS-1:0]                       new_dirty,
  output logic [WAYS-1:0][RANK_W-1:0]           new_rank,
  output logic [WAYS-1:0][ADDR_BITS-1:0]        new_addr
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned OLD_W = RANK_W + 1;

  logic [WAYS-1:0]   hit_vec;
  logic              any_hit;
  logic              any_free;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  free_way;
  logic [WAY_W-1:0]  victim_way;
  logic [WAY_W-1:0]  target;
  logic [OLD_W-1:0]  old_rank;
  logic              is_read;
  logic              is_write;
  logic              is_fill;
  logic              alloc;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = way_valid[i] && ((way_addr[i] >> TAG_SHIFT) == (addr >> TAG_SHIFT));
    end
  end

  assign any_hit  = |hit_vec;
  assign any_free = ~&way_valid;

  // Lowest-numbered way wins each search
  always_comb begin
    hit_way    = '0;
    free_way   = '0;
    victim_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WAY_W'(i);
      end
      if (!way_valid[i]) begin
        free_way = WAY_W'(i);
      end
      // In a full set the ranks are distinct; the oldest holds WAYS-1
      if (way_rank[i] == RANK_W'(WAYS - 1)) begin
        victim_way = WAY_W'(i);
      end
    end
  end

  assign is_read  = (mode == salc_pkg::MODE_READ);
  assign is_write = (mode == salc_pkg::MODE_WRITE);
  assign is_fill  = (mode == salc_pkg::MODE_FILL);
  assign alloc    = !any_hit && (is_write || is_fill);
  assign update   = (any_hit && (is_read || is_write)) || alloc;

  always_comb begin
    priority if (any_hit) begin
      target   = hit_way;
      old_rank = OLD_W'(way_rank[hit_way]);
    end else if (any_free) begin
      target   = free_way;
      old_rank = OLD_W'(WAYS);
    end else begin
      target   = victim_way;
      old_rank = OLD_W'(way_rank[victim_way]);
    end
  end

  always_comb begin
    new_valid = way_valid;
    new_dirty = way_dirty;
    new_rank  = way_rank;
    new_addr  = way_addr;
    for (int i = 0; i < WAYS; i++) begin
      if (way_valid[i] && (OLD_W'(way_rank[i]) < old_rank)) begin
        new_rank[i] = way_rank[i] + RANK_W'(1);
      end
    end
    new_rank[target]  = '0;
    new_valid[target] = 1'b1;
    new_addr[target]  = addr;
    new_dirty[target] = any_hit ? (way_dirty[target] | is_write) : is_write;
  end

  always_comb begin
    flags.hit             = any_hit && (is_read || is_write || is_fill);
    flags.forward_read    = !any_hit && is_read;
    flags.writeback_valid = alloc && !any_free && way_dirty[victim_way];
    flags.fault           = any_hit && is_fill;
    wb_addr = flags.writeback_valid ? way_addr[victim_way] : '0;
  end

endmodule

`default_nettype wire
